// File: rtl/avs_pkg.sv
package avs_pkg;

    localparam int DEF_STORE_DEPTH = 64;
    localparam int VALUE_W         = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      batch_end;
    } avs_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      final_flag;
        logic                      overflow;
    } avs_out_t;

    // controller -> datapath
    typedef struct packed {
        logic take;       // input transfer: capture item, pos <= count
        logic set_drop;   // store full: drop the item
        logic shift;      // move entry pos-1 up to pos, pos--
        logic place;      // write held value at pos, count++
        logic rd_emit;    // read address follows the emit index
        logic emit_load;  // load the output register
        logic emit_last;  // this load is the final result of the batch
    } avs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_end;     // batch_end of the offered item
        logic end_held;   // batch_end of the item being inserted
        logic full;
        logic empty;
        logic gt;         // entry pos-1 greater than held value
        logic pos_one;
        logic k_last;
        logic out_free;
        logic dropped;
    } avs_status_t;

endpackage

// File: rtl/avs_ram.sv
module avs_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/avs_ctrl.sv
module avs_ctrl
    import avs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  avs_status_t status,
    output avs_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CMP     = 3'd1;
    localparam logic [2:0] ST_PLACE   = 3'd2;
    localparam logic [2:0] ST_EMIT_RD = 3'd3;
    localparam logic [2:0] ST_EMIT_LD = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        sample_ready = 1'b0;
        state_next   = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.full)
                    begin
                        cmd.set_drop = 1'b1;
                        state_next   = status.in_end ? ST_EMIT_RD : ST_IDLE;
                    end
                    else
                    begin
                        state_next = status.empty ? ST_PLACE : ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                if (status.gt)
                begin
                    cmd.shift = 1'b1;
                    if (status.pos_one)
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = status.end_held ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = status.end_held ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                cmd.rd_emit = 1'b1;
                state_next  = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                cmd.rd_emit = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.emit_last = status.k_last;
                    state_next    = status.k_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/avs_dpath.sv
module avs_dpath
    import avs_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  avs_in_t     sample,
    output avs_out_t    result,
    output logic        result_valid,
    input  logic        result_ready,
    input  avs_cmd_t    cmd,
    output avs_status_t status
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);

    avs_in_t        value_reg;
    logic [CW-1:0]  count_reg;
    logic           drop_reg;
    logic [AW-1:0]  pos_reg;
    logic [AW-1:0]  k_reg;
    avs_out_t       out_reg;
    logic           out_valid_reg;

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [VALUE_W-1:0]        wr_data;
    logic [AW-1:0]             rd_addr;
    logic [VALUE_W-1:0]        rd_data;
    logic [CW-1:0]             count_m1;
    logic                      out_free;

    assign count_m1 = count_reg - CW'(1);
    assign out_free = !out_valid_reg || result_ready;

    // pos-2 during a shift: the entry below the one being moved
    always_comb
    begin
        if (cmd.rd_emit)
        begin
            rd_addr = k_reg;
        end
        else if (cmd.shift)
        begin
            rd_addr = pos_reg - AW'(2);
        end
        else
        begin
            rd_addr = count_m1[AW-1:0];
        end
    end

    assign wr_en   = cmd.shift || cmd.place;
    assign wr_addr = pos_reg;
    assign wr_data = cmd.shift ? rd_data : value_reg.sample_value;

    avs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            value_reg <= sample;
            pos_reg   <= count_reg[AW-1:0];
        end
        else if (cmd.shift)
        begin
            pos_reg <= pos_reg - AW'(1);
        end
        if (cmd.emit_load)
        begin
            out_reg.sorted_value <= rd_data;
            out_reg.final_flag   <= cmd.emit_last;
            out_reg.overflow     <= drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_drop)
            begin
                drop_reg <= 1'b1;
            end
            if (cmd.place)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
                if (cmd.emit_last)
                begin
                    k_reg     <= '0;
                    count_reg <= '0;
                    drop_reg  <= 1'b0;
                end
                else
                begin
                    k_reg <= k_reg + AW'(1);
                end
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.in_end   = sample.batch_end;
    assign status.end_held = value_reg.batch_end;
    assign status.full     = (count_reg == CW'(STORE_DEPTH));
    assign status.empty    = (count_reg == '0);
    assign status.gt       = ($signed(rd_data) > value_reg.sample_value);
    assign status.pos_one  = (pos_reg == AW'(1));
    assign status.k_last   = (CW'(k_reg) == count_m1);
    assign status.out_free = out_free;
    assign status.dropped  = drop_reg;

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

// File: rtl/ascending_value_sorter_unit.sv
// Ascending value sorter.
// Input channel (sample_valid/sample_ready/sample): one signed 32-bit value per
// transfer; batch_end marks the last value of a batch. Output channel
// (result_valid/result_ready/result): after the batch end, every held value is
// returned in ascending order, final_flag set on the largest one, overflow set
// on all results of a batch that had more than STORE_DEPTH values (extras are
// dropped).
// Timing: an item is taken, then every held value greater than it is moved up
// one store entry per cycle through the single write port of the store RAM,
// then the item is placed; a dropped item is only taken. Each result is a
// registered RAM read, then an output load, which waits while the output
// register holds a result not yet taken; sample_ready is low while an item is
// inserted and from the batch end until the final result is loaded.
// Reset empties the store (count and drop mark cleared) and leaves no result
// pending; store contents are not cleared and need not be.
// A stalled receiver holds the current result in the output register; the
// drain waits on it, and a new batch may start while the final result waits.
module ascending_value_sorter_unit
    import avs_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sample_valid,
    output logic     sample_ready,
    input  avs_in_t  sample,
    output logic     result_valid,
    input  logic     result_ready,
    output avs_out_t result
);

    avs_cmd_t    cmd;
    avs_status_t status;

    avs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    avs_dpath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .status       (status)
    );

    // after the final load the block takes input again
    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load && cmd.emit_last |=> sample_ready)
        else $error("not ready after final result");

    // the store is never written while input transfers are taken
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready |-> !(cmd.shift || cmd.place))
        else $error("store write while idle");

    // a placed value leaves the store non-empty
    a_place_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |=> !status.empty)
        else $error("store empty after place");

    // a transfer into a full store marks the batch as overflowed
    a_drop_marked: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && status.full |=> status.dropped)
        else $error("drop not recorded");

endmodule
